[rtl/srs_pkg.sv]
// ----------------------------------------------------------------------------
// srs_pkg
// Shared constants and types of the selective-repeat sender.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int MAX_FRAMES_DEF = 1024;
  localparam int WINDOW_MAX_DEF = 32;
  localparam int TIME_BITS_DEF  = 32;

  localparam int WINDOW_W  = 6;
  localparam int TIMEOUT_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [WINDOW_W-1:0]  WINDOW_RESET  = 6'd4;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd2000;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    KIND_SEND   = 2'd0,
    KIND_RESEND = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

endpackage

[rtl/srs_ram.sv]
// ----------------------------------------------------------------------------
// srs_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module srs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = srs_pkg::MAX_FRAMES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/selective_repeat_sender.sv]
// ----------------------------------------------------------------------------
// selective_repeat_sender
// Selective-repeat ARQ sender: per round, takes an ack and slides the base,
// sends new frames up to the window end taken at accept, then resends
// timed-out frames, and closes with a status.
// Throughput: one round at a time, bound by the single read port of the
//   ack and stamp RAMs (one entry per cycle in slide and scan; scan holds
//   while a resend waits for the output).
// Reset: synchronous, active low; afterwards all MAX_FRAMES entries of the
//   ack map are cleared with in_tready low. Config writes are taken at all
//   times outside reset.
// ----------------------------------------------------------------------------
module selective_repeat_sender #(
  parameter int MAX_FRAMES = srs_pkg::MAX_FRAMES_DEF,
  parameter int WINDOW_MAX = srs_pkg::WINDOW_MAX_DEF,
  parameter int TIME_BITS  = srs_pkg::TIME_BITS_DEF,
  localparam int AW        = $clog2(MAX_FRAMES),
  localparam int FW        = $clog2(MAX_FRAMES + 1),
  localparam int IN_W      = ((AW + TIME_BITS + 7) / 8) * 8,
  localparam int OUT_W     = ((AW + FW + 1 + 7) / 8) * 8,
  localparam int CFG_W     = (FW > srs_pkg::TIMEOUT_W) ? FW : srs_pkg::TIMEOUT_W
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [IN_W-1:0]                in_tdata,   // ack_seq, current_time
  input  logic                           in_tuser,   // operation
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_W-1:0]               out_tdata,  // frame_seq, base_seq, all_done
  output logic [1:0]                     out_tuser,  // kind
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]               cfg_data
);

  localparam int NW    = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = ((FW > srs_pkg::WINDOW_W) ? FW : srs_pkg::WINDOW_W) + 1;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_ACK    = 7'b0000100,
    ST_SLIDE  = 7'b0001000,
    ST_SEND   = 7'b0010000,
    ST_SCAN   = 7'b0100000,
    ST_STATUS = 7'b1000000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [srs_pkg::WINDOW_W-1:0]   window_r;
  logic [FW-1:0]                  total_r;
  logic [srs_pkg::TIMEOUT_W-1:0]  timeout_r;

  logic [AW-1:0]                  clr_r, clr_nxt;
  logic [FW-1:0]                  base_r, base_nxt;
  logic [FW-1:0]                  next_r, next_nxt;
  logic [FW-1:0]                  win_end_r, win_end_nxt;
  logic [NW-1:0]                  n_r, n_nxt;
  logic [FW-1:0]                  scan_r, scan_nxt;
  logic                           ev_vld_r, ev_vld_nxt;
  logic [AW-1:0]                  ev_idx_r, ev_idx_nxt;
  logic                           fwd_r, fwd_nxt;

  logic                           op_r;
  logic [AW-1:0]                  ack_r;
  logic [TIME_BITS-1:0]           now_r;

  logic                           out_vld_r;
  srs_pkg::kind_t                 out_kind_r;
  logic [AW-1:0]                  out_seq_r;
  logic [FW-1:0]                  out_base_r;
  logic                           out_done_r;
  logic                           out_last_r;

  logic [srs_pkg::WINDOW_W-1:0]   win_eff;
  logic [FW-1:0]                  total_eff;
  logic [SUM_W-1:0]               win_sum;
  logic [FW-1:0]                  limit;
  logic [FW-1:0]                  base_inc;
  logic                           ack_ok;
  logic                           out_free;
  logic [TIME_BITS-1:0]           age;
  logic                           hit;

  logic                           ack_we, ack_re;
  logic [AW-1:0]                  ack_waddr, ack_raddr;
  logic                           ack_wdata, ack_rdata;
  logic                           st_we, st_re;
  logic [AW-1:0]                  st_waddr, st_raddr;
  logic [TIME_BITS-1:0]           st_rdata;

  logic                           load;
  srs_pkg::kind_t                 load_kind;
  logic [AW-1:0]                  load_seq;
  logic                           load_last;

  srs_ram #(.WIDTH(1), .DEPTH(MAX_FRAMES)) u_ack_ram (
    .clk   (clk),
    .we    (ack_we),
    .waddr (ack_waddr),
    .wdata (ack_wdata),
    .re    (ack_re),
    .raddr (ack_raddr),
    .rdata (ack_rdata)
  );

  srs_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_FRAMES)) u_stamp_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (now_r),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign win_eff   = (window_r > srs_pkg::WINDOW_W'(WINDOW_MAX)) ?
                     srs_pkg::WINDOW_W'(WINDOW_MAX) : window_r;
  assign total_eff = (total_r > FW'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : total_r;
  assign win_sum   = SUM_W'(base_r) + SUM_W'(win_eff);
  assign limit     = (win_sum < SUM_W'(total_eff)) ? FW'(win_sum) : total_eff;
  assign base_inc  = base_r + FW'(1);
  assign ack_ok    = FW'(ack_r) < total_eff;
  assign out_free  = !out_vld_r || out_tready;
  assign age       = now_r - st_rdata;
  assign hit       = ev_vld_r && (FW'(ev_idx_r) < next_r) && !ack_rdata &&
                     (age > TIME_BITS'(timeout_r));

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    base_nxt    = base_r;
    next_nxt    = next_r;
    win_end_nxt = win_end_r;
    n_nxt       = n_r;
    scan_nxt    = scan_r;
    ev_vld_nxt  = ev_vld_r;
    ev_idx_nxt  = ev_idx_r;
    fwd_nxt     = fwd_r;
    in_tready   = 1'b0;
    ack_we      = 1'b0;
    ack_waddr   = ack_r;
    ack_wdata   = 1'b1;
    ack_re      = 1'b0;
    ack_raddr   = base_r[AW-1:0];
    st_we       = 1'b0;
    st_waddr    = next_r[AW-1:0];
    st_re       = 1'b0;
    st_raddr    = scan_r[AW-1:0];
    load        = 1'b0;
    load_kind   = srs_pkg::KIND_STATUS;
    load_seq    = '0;
    load_last   = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        ack_we    = 1'b1;
        ack_waddr = clr_r;
        ack_wdata = 1'b0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(MAX_FRAMES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          win_end_nxt = limit;
          n_nxt       = '0;
          state_nxt   = ST_ACK;
        end
      end
      ST_ACK: begin
        state_nxt = ST_SEND;
        if (op_r && ack_ok) begin
          ack_we = 1'b1;
          if (base_r < total_eff) begin
            ack_re    = 1'b1;
            fwd_nxt   = (FW'(ack_r) == base_r);
            state_nxt = ST_SLIDE;
          end
        end
      end
      ST_SLIDE: begin
        fwd_nxt   = 1'b0;
        state_nxt = ST_SEND;
        if (ack_rdata || fwd_r) begin
          base_nxt = base_inc;
          if (base_inc < total_eff) begin
            ack_re    = 1'b1;
            ack_raddr = base_inc[AW-1:0];
            state_nxt = ST_SLIDE;
          end
        end
      end
      ST_SEND: begin
        if ((next_r < win_end_r) && (n_r != NW'(WINDOW_MAX))) begin
          if (out_free) begin
            load      = 1'b1;
            load_kind = srs_pkg::KIND_SEND;
            load_seq  = next_r[AW-1:0];
            st_we     = 1'b1;
            next_nxt  = next_r + FW'(1);
            n_nxt     = n_r + NW'(1);
          end
        end else begin
          win_end_nxt = limit;
          scan_nxt    = base_r;
          ev_vld_nxt  = 1'b0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (n_r == NW'(WINDOW_MAX)) begin
          ev_vld_nxt = 1'b0;
          state_nxt  = ST_STATUS;
        end else begin
          if (hit && out_free) begin
            load      = 1'b1;
            load_kind = srs_pkg::KIND_RESEND;
            load_seq  = ev_idx_r;
            st_we     = 1'b1;
            st_waddr  = ev_idx_r;
            n_nxt     = n_r + NW'(1);
          end
          if (!hit || out_free) begin
            if (scan_r < win_end_r) begin
              ack_re     = 1'b1;
              ack_raddr  = scan_r[AW-1:0];
              st_re      = 1'b1;
              ev_vld_nxt = 1'b1;
              ev_idx_nxt = scan_r[AW-1:0];
              scan_nxt   = scan_r + FW'(1);
            end else begin
              ev_vld_nxt = 1'b0;
              if (!ev_vld_r) begin
                state_nxt = ST_STATUS;
              end
            end
          end
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          load      = 1'b1;
          load_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_r     <= '0;
      base_r    <= '0;
      next_r    <= '0;
      win_end_r <= '0;
      n_r       <= '0;
      scan_r    <= '0;
      ev_vld_r  <= 1'b0;
      ev_idx_r  <= '0;
      fwd_r     <= 1'b0;
      out_vld_r <= 1'b0;
      window_r  <= srs_pkg::WINDOW_RESET;
      total_r   <= '0;
      timeout_r <= srs_pkg::TIMEOUT_RESET;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      base_r    <= base_nxt;
      next_r    <= next_nxt;
      win_end_r <= win_end_nxt;
      n_r       <= n_nxt;
      scan_r    <= scan_nxt;
      ev_vld_r  <= ev_vld_nxt;
      ev_idx_r  <= ev_idx_nxt;
      fwd_r     <= fwd_nxt;
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          srs_pkg::CFG_WINDOW:  window_r  <= cfg_data[srs_pkg::WINDOW_W-1:0];
          srs_pkg::CFG_TOTAL:   total_r   <= cfg_data[FW-1:0];
          srs_pkg::CFG_TIMEOUT: timeout_r <= cfg_data[srs_pkg::TIMEOUT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r  <= in_tuser;
      ack_r <= in_tdata[AW-1:0];
      now_r <= in_tdata[AW +: TIME_BITS];
    end
    if (load) begin
      out_kind_r <= load_kind;
      out_seq_r  <= load_seq;
      out_base_r <= base_r;
      out_done_r <= (base_r >= total_eff);
      out_last_r <= load_last;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_W'({out_done_r, out_base_r, out_seq_r});

  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    base_r <= FW'(MAX_FRAMES))
    else $error("base beyond frame count");

  a_next_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> next_r >= $past(next_r))
    else $error("next index moved back");

  a_round_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(WINDOW_MAX))
    else $error("too many frame items in one round");

  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_kind_r == srs_pkg::KIND_STATUS)))
    else $error("tlast not on status item");

endmodule

[verif/selective_repeat_sender_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_sender_checker
// Watches the config, round and command channels of the selective-repeat
// sender. It keeps its own copy of the window state and predicts the send,
// resend and status items of each round. It then compares every command item,
// field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module selective_repeat_sender_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [47:0]                   in_tdata,   // ack_seq, current_time
  input  logic                          in_tuser,   // operation
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [23:0]                   out_tdata,  // frame_seq, base_seq, all_done
  input  logic [1:0]                    out_tuser,  // kind
  input  logic                          out_tlast,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [srs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output int                            fail_count,
  output int                            pending,
  output int                            checked
);

  localparam int FRAMES  = srs_pkg::MAX_FRAMES_DEF;
  localparam int WIN_CAP = srs_pkg::WINDOW_MAX_DEF;

  typedef struct packed {
    srs_pkg::kind_t kind;
    logic [9:0]     seq;
    logic [10:0]    base;
    logic           done;
    logic           is_last;
  } frame_cmd_t;

  frame_cmd_t  expected_cmds[$];

  logic [5:0]  win_reg;
  logic [10:0] total_reg;
  logic [15:0] timeout_reg;
  int unsigned base_idx;
  int unsigned next_idx;
  bit          acked [FRAMES];
  logic [31:0] stamp [FRAMES];
  int          errors;
  int          matched;

  initial begin
    errors  = 0;
    matched = 0;
  end

  task automatic predict_round(input logic op, input logic [9:0] ack, input logic [31:0] now);
    int unsigned w;
    int unsigned tot;
    int unsigned stop;
    int unsigned n;
    logic [31:0] age;
    frame_cmd_t  c;
    frame_cmd_t  round_cmds[$];
    w   = (win_reg > WIN_CAP) ? WIN_CAP : win_reg;
    tot = (total_reg > FRAMES) ? FRAMES : total_reg;
    n   = 0;
    c   = '0;
    while (next_idx < base_idx + w && next_idx < tot && n < WIN_CAP) begin
      stamp[next_idx] = now;
      c.kind = srs_pkg::KIND_SEND;
      c.seq  = next_idx[9:0];
      round_cmds.push_back(c);
      n++;
      next_idx++;
    end
    if (op && ack < tot) begin
      acked[ack] = 1'b1;
      while (base_idx < tot && acked[base_idx]) base_idx++;
    end
    stop = base_idx + w;
    if (stop > tot) stop = tot;
    for (int unsigned i = base_idx; i < stop && n < WIN_CAP; i++) begin
      if (i < next_idx && !acked[i]) begin
        age = now - stamp[i];
        if (age > {16'd0, timeout_reg}) begin
          stamp[i] = now;
          c.kind = srs_pkg::KIND_RESEND;
          c.seq  = i[9:0];
          round_cmds.push_back(c);
          n++;
        end
      end
    end
    c.kind = srs_pkg::KIND_STATUS;
    c.seq  = '0;
    round_cmds.push_back(c);
    foreach (round_cmds[k]) begin
      c         = round_cmds[k];
      c.base    = base_idx[10:0];
      c.done    = (base_idx >= tot);
      c.is_last = (k == round_cmds.size() - 1);
      expected_cmds.push_back(c);
    end
  endtask

  always @(posedge clk) begin
    frame_cmd_t want;
    if (!rst_n) begin
      win_reg     = srs_pkg::WINDOW_RESET;
      total_reg   = '0;
      timeout_reg = srs_pkg::TIMEOUT_RESET;
      base_idx    = 0;
      next_idx    = 0;
      foreach (acked[i]) begin
        acked[i] = 1'b0;
        stamp[i] = '0;
      end
      expected_cmds.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_cmds.size() == 0) begin
          $error("unexpected command item: kind %0d, frame %0d", out_tuser, out_tdata[9:0]);
          errors++;
        end else begin
          want = expected_cmds.pop_front();
          matched++;
          if (out_tuser !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_tuser);
            errors++;
          end
          if (out_tdata[9:0] !== want.seq) begin
            $error("frame_seq: expected %0d, got %0d", want.seq, out_tdata[9:0]);
            errors++;
          end
          if (out_tdata[20:10] !== want.base) begin
            $error("base_seq: expected %0d, got %0d", want.base, out_tdata[20:10]);
            errors++;
          end
          if (out_tdata[21] !== want.done) begin
            $error("all_done: expected %0d, got %0d", want.done, out_tdata[21]);
            errors++;
          end
          if (out_tlast !== want.is_last) begin
            $error("last: expected %0d, got %0d", want.is_last, out_tlast);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          srs_pkg::CFG_WINDOW:  win_reg     = cfg_data[5:0];
          srs_pkg::CFG_TOTAL:   total_reg   = cfg_data[10:0];
          srs_pkg::CFG_TIMEOUT: timeout_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_round(in_tuser, in_tdata[9:0], in_tdata[41:10]);
    end
    pending    <= expected_cmds.size();
    fail_count <= errors;
    checked    <= matched;
  end

endmodule

[verif/selective_repeat_sender_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_sender_test
// Drives service rounds and register writes into the selective-repeat sender:
// a directed pass over window, total and timeout extremes, acks on unsent and
// out-of-range frames, time wrap and shrinking the transfer below the base,
// then random transfers with mostly in-window acks. Both channels idle at
// random, the output is held off once for a long stretch.
// ----------------------------------------------------------------------------
module selective_repeat_sender_test;

  localparam int IN_W        = 48;
  localparam int OUT_W       = 24;
  localparam int CFG_W       = 16;
  localparam int FRAMES      = srs_pkg::MAX_FRAMES_DEF;
  localparam int HOLD_CYCLES = 600;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [srs_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [IN_W-1:0]               in_tdata   = '0;
  logic                          in_tuser   = 1'b0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [OUT_W-1:0]              out_tdata;
  logic [1:0]                    out_tuser;
  logic                          out_tlast;
  logic                          cfg_valid  = 1'b0;
  logic                          cfg_ready;
  logic [srs_pkg::CFG_IDX_W-1:0] cfg_index  = srs_pkg::CFG_WINDOW;
  logic [CFG_W-1:0]              cfg_data   = '0;

  int          fail_count;
  int          pending;
  int          checked;
  int          cycles      = 0;
  int          send_idle   = 35;
  int          recv_idle   = 70;
  int          hold_asked  = 0;
  int          hold_taken  = 0;
  int          hold_left   = 0;
  int          rounds_sent = 0;
  int          random_cnt  = 0;
  int          settings    = 0;
  int unsigned cur_win     = 4;
  int unsigned cur_total   = 0;
  int unsigned ack_floor   = 0;
  logic [31:0] now_ms      = '0;
  bit          acked_tb [FRAMES];

  selective_repeat_sender dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  selective_repeat_sender_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // output side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  function automatic int unsigned eff_total();
    return (cur_total > FRAMES) ? FRAMES : cur_total;
  endfunction

  task automatic send_round(input logic op, input logic [9:0] ack, input logic [31:0] t);
    if ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, t, ack};
    if (op && ack < eff_total()) acked_tb[ack] = 1'b1;
    now_ms = t;
    do @(posedge clk); while (!in_tready);
    rounds_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [srs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(input int unsigned w, input int unsigned tot, input int unsigned tmo,
                          input bit touch_spare);
    drain();
    if (touch_spare) write_reg(CFG_SPARE, CFG_W'($urandom));
    write_reg(srs_pkg::CFG_WINDOW, CFG_W'(w));
    write_reg(srs_pkg::CFG_TOTAL, CFG_W'(tot));
    write_reg(srs_pkg::CFG_TIMEOUT, CFG_W'(tmo));
    cfg_valid <= 1'b0;
    cur_win   = w;
    cur_total = tot;
    settings++;
  endtask

  task automatic random_round();
    int unsigned r;
    int unsigned span;
    int unsigned pick;
    logic        op;
    logic [9:0]  ack;
    logic [31:0] t;
    random_cnt++;
    if (random_cnt < 153) begin
      send_idle = 35;
      recv_idle = 70;
    end else if (random_cnt < 306) begin
      send_idle = 70;
      recv_idle = 35;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    r = $urandom_range(0, 99);
    if (r < 12) begin
      op  = 1'b0;
      ack = 10'($urandom);
    end else if (r < 22) begin
      op  = 1'b1;
      ack = 10'($urandom);
    end else begin
      op = 1'b1;
      while (ack_floor < FRAMES && acked_tb[ack_floor]) ack_floor++;
      span = (cur_win == 0) ? 1 : ((cur_win > 32) ? 32 : cur_win);
      pick = ($urandom_range(0, 99) < 40) ? ack_floor
                                          : ack_floor + $urandom_range(0, span - 1);
      ack  = (pick < FRAMES) ? pick[9:0] : 10'($urandom);
    end
    r = $urandom_range(0, 99);
    if (r < 3) t = $urandom;
    else if (r < 12) t = now_ms + $urandom_range(0, 70000);
    else t = now_ms + $urandom_range(0, 400);
    send_round(op, ack, t);
  endtask

  initial begin
    int unsigned w;
    int unsigned tot;
    int unsigned tmo;
    int          n;
    int          waited;
    foreach (acked_tb[i]) acked_tb[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty transfer under reset settings, ack out of range
    send_round(1'b0, 10'd0, 32'd0);
    send_round(1'b1, 10'd5, 32'd0);

    // window zero: acks mark and slide, no frames go out, only status items
    set_regs(0, 10, 2000, 1'b1);
    send_round(1'b0, 10'd0, 32'd10);
    send_round(1'b1, 10'd3, 32'd20);
    send_round(1'b1, 10'd0, 32'd30);

    // oversized window and total, zero timeout: full rounds of sends, then resends
    set_regs(63, 2047, 0, 1'b0);
    send_round(1'b0, 10'd0, 32'd100);
    send_round(1'b0, 10'd0, 32'd101);
    send_round(1'b1, 10'd1023, 32'd101);
    send_round(1'b0, 10'd0, 32'd200);

    set_regs(32, 40, 65535, 1'b0);
    send_round(1'b1, 10'd1, 32'd300);
    send_round(1'b1, 10'd2, 32'd301);
    send_round(1'b0, 10'd0, 32'd70300);

    // total dropped under the base
    set_regs(4, 0, 100, 1'b0);
    send_round(1'b0, 10'd0, 32'd70400);
    send_round(1'b1, 10'd1, 32'd70401);

    // time wraps past zero
    set_regs(4, 40, 100, 1'b0);
    send_round(1'b0, 10'd0, 32'hFFFF_FF00);
    send_round(1'b1, 10'd4, 32'hFFFF_FF10);
    send_round(1'b0, 10'd0, 32'h0000_0050);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin w = 8;  tot = 100;  tmo = 300;   n = 60; end
        1: begin w = 1;  tot = 130;  tmo = 50;    n = 50; end
        2: begin w = 32; tot = 200;  tmo = 1000;  n = 60; end
        3: begin w = 63; tot = 260;  tmo = 0;     n = 40; end
        4: begin w = 16; tot = 2047; tmo = 65535; n = 50; end
        5: begin
          while (ack_floor < FRAMES && acked_tb[ack_floor]) ack_floor++;
          w   = 6;
          tot = (ack_floor + 20 > FRAMES) ? FRAMES : ack_floor + 20;
          tmo = 200;
          n   = 70;
        end
        6: begin w = 32; tot = 1024; tmo = 2000;  n = 60; end
        default: begin
          w   = $urandom_range(0, 63);
          tot = 1024;
          tmo = $urandom_range(0, 65535);
          n   = 70;
        end
      endcase
      set_regs(w, tot, tmo, 1'b0);
      if (p == 6) now_ms = 32'hFFFF_0000;
      if (p == 2) hold_asked <= hold_asked + 1;
      for (int j = 0; j < n; j++) begin
        random_round();
        if (p == 1 && j == 25) drain();
      end
    end

    in_tvalid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < 20000);
    repeat (80) @(posedge clk);
    if (pending != 0) $error("%0d expected command items never arrived", pending);

    $display("Ran %0d service rounds over %0d register settings, %0d command items checked.",
             rounds_sent, settings, checked);
    $display("Window 0..63, total 0..2047, timeout 0..65535, time wrap, long output stall.");
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
